FILE: rtl/tevg_pkg.sv
// ----------------------------------------------------------------------------
// Touch event generator package
// Shared widths, register indexes, event codes and the control and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tevg_pkg;

    // Field widths
    localparam int RAW_W   = 12;
    localparam int SIZE_W  = 11;
    localparam int POS_W   = 12;
    localparam int THR_W   = 8;
    localparam int STAMP_W = 32;
    localparam int KIND_W  = 2;

    // Divider geometry: the product needs 24 signed bits, its magnitude 23.
    // Quotients of 2048 and up saturate, so only 11 quotient bits are formed.
    localparam int PROD_W  = RAW_W + 1 + SIZE_W;
    localparam int MAG_W   = PROD_W - 1;
    localparam int QBITS   = POS_W - 1;
    localparam int CNT_W   = $clog2(QBITS);

    // Stream payload widths
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 56;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_X_MIN  = 3'd0;
    localparam logic [2:0] REG_X_MAX  = 3'd1;
    localparam logic [2:0] REG_Y_MIN  = 3'd2;
    localparam logic [2:0] REG_Y_MAX  = 3'd3;
    localparam logic [2:0] REG_WIDTH  = 3'd4;
    localparam logic [2:0] REG_HEIGHT = 3'd5;
    localparam logic [2:0] REG_THRESH = 3'd6;

    // Register reset values
    localparam logic [RAW_W-1:0]  RST_X_MIN  = 12'd219;
    localparam logic [RAW_W-1:0]  RST_X_MAX  = 12'd3807;
    localparam logic [RAW_W-1:0]  RST_Y_MIN  = 12'd500;
    localparam logic [RAW_W-1:0]  RST_Y_MAX  = 12'd3660;
    localparam logic [SIZE_W-1:0] RST_WIDTH  = 11'd320;
    localparam logic [SIZE_W-1:0] RST_HEIGHT = 11'd240;
    localparam logic [THR_W-1:0]  RST_THRESH = 8'd2;

    // Event codes
    localparam logic [KIND_W-1:0] EV_START = 2'd0;
    localparam logic [KIND_W-1:0] EV_MOVE  = 2'd1;
    localparam logic [KIND_W-1:0] EV_END   = 2'd2;

    // Commands from the controller
    typedef struct packed {
        logic load;    // capture an accepted input word
        logic setup;   // form the scaled numerator and denominator
        logic prep;    // take magnitudes and seed the divider
        logic step;    // one restoring division step
        logic commit;  // update touch state and the output word
    } tevg_cmd_t;

    // Status back to the controller
    typedef struct packed {
        logic pressed; // latched touch flag of the current word
        logic emit;    // the current word produces an event
    } tevg_stat_t;

    // Configuration bundle
    typedef struct packed {
        logic [RAW_W-1:0]  x_min;
        logic [RAW_W-1:0]  x_max;
        logic [RAW_W-1:0]  y_min;
        logic [RAW_W-1:0]  y_max;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
        logic [THR_W-1:0]  thresh;
    } tevg_cfg_t;

endpackage

FILE: rtl/touch_event_generator.sv
// ----------------------------------------------------------------------------
// Touch event generator
// Turns touch panel polls into start, move and end events with calibrated
// screen coordinates; holds the configuration registers behind the APB port.
// ----------------------------------------------------------------------------
// A touched word passes through capture, multiply, divider seeding, the
// 11-step divider and the commit; an untouched word skips seeding and the
// divider. A new input word is taken only after the last one commits.
// A waiting event word does not block acceptance of the next input word.
// Reset (rst_n, asynchronous, active low) clears the touch state, the stored
// point to -1, the stored time to 0, and loads the calibration defaults.
// ----------------------------------------------------------------------------
module touch_event_generator
    import tevg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // raw_x[11:0], raw_y[23:12], now_ms[55:24]
    input  logic                s_tuser,  // pressed
    // Event stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // pos_x[11:0], pos_y[23:12], stamp_ms[55:24]
    output logic [KIND_W-1:0]   m_tuser,  // event_kind
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    tevg_cfg_t               cfg_reg;
    tevg_cmd_t               cmd;
    tevg_stat_t              stat;
    logic [2:0]              reg_idx;
    logic                    wr_en;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [STAMP_W-1:0]      stamp_ms;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_min  <= RST_X_MIN;
            cfg_reg.x_max  <= RST_X_MAX;
            cfg_reg.y_min  <= RST_Y_MIN;
            cfg_reg.y_max  <= RST_Y_MAX;
            cfg_reg.width  <= RST_WIDTH;
            cfg_reg.height <= RST_HEIGHT;
            cfg_reg.thresh <= RST_THRESH;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_X_MIN:  cfg_reg.x_min  <= pwdata[RAW_W-1:0];
                REG_X_MAX:  cfg_reg.x_max  <= pwdata[RAW_W-1:0];
                REG_Y_MIN:  cfg_reg.y_min  <= pwdata[RAW_W-1:0];
                REG_Y_MAX:  cfg_reg.y_max  <= pwdata[RAW_W-1:0];
                REG_WIDTH:  cfg_reg.width  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: cfg_reg.height <= pwdata[SIZE_W-1:0];
                REG_THRESH: cfg_reg.thresh <= pwdata[THR_W-1:0];
                default:    ;
            endcase
        end
    end

    // Configuration register reads
    always_comb
    begin
        case (reg_idx)
            REG_X_MIN:  prdata = {{(32-RAW_W){1'b0}}, cfg_reg.x_min};
            REG_X_MAX:  prdata = {{(32-RAW_W){1'b0}}, cfg_reg.x_max};
            REG_Y_MIN:  prdata = {{(32-RAW_W){1'b0}}, cfg_reg.y_min};
            REG_Y_MAX:  prdata = {{(32-RAW_W){1'b0}}, cfg_reg.y_max};
            REG_WIDTH:  prdata = {{(32-SIZE_W){1'b0}}, cfg_reg.width};
            REG_HEIGHT: prdata = {{(32-SIZE_W){1'b0}}, cfg_reg.height};
            REG_THRESH: prdata = {{(32-THR_W){1'b0}}, cfg_reg.thresh};
            default:    prdata = '0;
        endcase
    end

    // Sequencer
    tevg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Datapath
    tevg_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg        (cfg_reg),
        .in_pressed (s_tuser),
        .in_raw_x   (s_tdata[11:0]),
        .in_raw_y   (s_tdata[23:12]),
        .in_now     (s_tdata[55:24]),
        .event_kind (m_tuser),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .stamp_ms   (stamp_ms)
    );

    // Event word packing
    assign m_tdata = {stamp_ms, pos_y, pos_x};

endmodule

FILE: rtl/tevg_scale.sv
// ----------------------------------------------------------------------------
// Touch event generator axis scaler
// Maps one raw reading to a screen coordinate: (raw-min)*size/(max-min),
// truncated toward zero and saturated, using a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module tevg_scale
    import tevg_pkg::*;
(
    input  logic                     clk,
    input  tevg_cmd_t                cmd,
    input  logic [RAW_W-1:0]         raw,
    input  logic [RAW_W-1:0]         lo,
    input  logic [RAW_W-1:0]         hi,
    input  logic [SIZE_W-1:0]        size,
    output logic signed [POS_W-1:0]  pos
);

    logic signed [PROD_W-1:0] num_reg;
    logic signed [RAW_W:0]    den_reg;
    logic [RAW_W-1:0]         den_mag_reg;
    logic [RAW_W-1:0]         rem_reg;
    logic [QBITS-1:0]         dvd_reg;
    logic [QBITS-1:0]         quo_reg;
    logic                     neg_reg;
    logic                     zero_reg;
    logic                     ovf_reg;

    logic signed [RAW_W:0]    diff;
    logic signed [RAW_W:0]    size_s;
    logic [PROD_W-1:0]        num_abs;
    logic [RAW_W:0]           den_abs;
    logic [MAG_W-1:0]         num_mag;
    logic [RAW_W-1:0]         den_mag;
    logic [RAW_W:0]           trial;
    logic [RAW_W+1:0]         sub;
    logic [POS_W-1:0]         q_ext;

    // Operand formation and magnitudes
    always_comb
    begin
        diff    = $signed({1'b0, raw}) - $signed({1'b0, lo});
        size_s  = $signed({2'b00, size});
        num_abs = num_reg[PROD_W-1] ? PROD_W'(-num_reg) : PROD_W'(num_reg);
        den_abs = den_reg[RAW_W] ? (RAW_W+1)'(-den_reg) : (RAW_W+1)'(den_reg);
        num_mag = num_abs[MAG_W-1:0];
        den_mag = den_abs[RAW_W-1:0];
        trial   = {rem_reg, dvd_reg[QBITS-1]};
        sub     = {1'b0, trial} - {2'b00, den_mag_reg};
    end

    // Multiply, seed and divide
    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            num_reg <= PROD_W'(diff) * PROD_W'(size_s);
            den_reg <= $signed({1'b0, hi}) - $signed({1'b0, lo});
        end
        else if (cmd.prep)
        begin
            den_mag_reg <= den_mag;
            neg_reg     <= num_reg[PROD_W-1] ^ den_reg[RAW_W];
            zero_reg    <= (den_reg == '0);
            ovf_reg     <= (num_mag >= {den_mag, {QBITS{1'b0}}});
            rem_reg     <= num_mag[MAG_W-1:QBITS];
            dvd_reg     <= num_mag[QBITS-1:0];
            quo_reg     <= '0;
        end
        else if (cmd.step)
        begin
            if (!sub[RAW_W+1])
            begin
                rem_reg <= sub[RAW_W-1:0];
            end
            else
            begin
                rem_reg <= trial[RAW_W-1:0];
            end
            quo_reg <= {quo_reg[QBITS-2:0], ~sub[RAW_W+1]};
            dvd_reg <= {dvd_reg[QBITS-2:0], 1'b0};
        end
    end

    // Sign and saturation
    always_comb
    begin
        q_ext = {1'b0, quo_reg};
        if (zero_reg)
        begin
            pos = '0;
        end
        else if (ovf_reg)
        begin
            pos = neg_reg ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        else if (neg_reg)
        begin
            pos = POS_W'(-q_ext);
        end
        else
        begin
            pos = q_ext;
        end
    end

endmodule

FILE: rtl/tevg_datapath.sv
// ----------------------------------------------------------------------------
// Touch event generator datapath
// Holds the input word, both axis scalers, the touch state and the output
// word, and decides whether the current poll produces an event.
// ----------------------------------------------------------------------------
module tevg_datapath
    import tevg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  tevg_cmd_t               cmd,
    output tevg_stat_t              stat,
    input  tevg_cfg_t               cfg,
    input  logic                    in_pressed,
    input  logic [RAW_W-1:0]        in_raw_x,
    input  logic [RAW_W-1:0]        in_raw_y,
    input  logic [STAMP_W-1:0]      in_now,
    output logic [KIND_W-1:0]       event_kind,
    output logic signed [POS_W-1:0] pos_x,
    output logic signed [POS_W-1:0] pos_y,
    output logic [STAMP_W-1:0]      stamp_ms
);

    logic                    pressed_reg;
    logic [RAW_W-1:0]        raw_x_reg;
    logic [RAW_W-1:0]        raw_y_reg;
    logic [STAMP_W-1:0]      now_reg;

    logic                    active_reg;
    logic signed [POS_W-1:0] prev_x_reg;
    logic signed [POS_W-1:0] prev_y_reg;
    logic [STAMP_W-1:0]      tstamp_reg;

    logic [KIND_W-1:0]       kind_reg;
    logic signed [POS_W-1:0] out_x_reg;
    logic signed [POS_W-1:0] out_y_reg;
    logic [STAMP_W-1:0]      out_t_reg;

    logic signed [POS_W-1:0] sx;
    logic signed [POS_W-1:0] sy;
    logic signed [POS_W:0]   dx;
    logic signed [POS_W:0]   dy;
    logic [POS_W:0]          adx;
    logic [POS_W:0]          ady;
    logic                    far;
    logic                    emit;
    logic [KIND_W-1:0]       kind_next;
    logic signed [POS_W-1:0] ev_x;
    logic signed [POS_W-1:0] ev_y;
    logic [STAMP_W-1:0]      ev_t;

    // Input word capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pressed_reg <= in_pressed;
            raw_x_reg   <= in_raw_x;
            raw_y_reg   <= in_raw_y;
            now_reg     <= in_now;
        end
    end

    // Axis scalers
    tevg_scale u_scale_x
    (
        .clk  (clk),
        .cmd  (cmd),
        .raw  (raw_x_reg),
        .lo   (cfg.x_min),
        .hi   (cfg.x_max),
        .size (cfg.width),
        .pos  (sx)
    );

    tevg_scale u_scale_y
    (
        .clk  (clk),
        .cmd  (cmd),
        .raw  (raw_y_reg),
        .lo   (cfg.y_min),
        .hi   (cfg.y_max),
        .size (cfg.height),
        .pos  (sy)
    );

    // Movement test and event selection
    always_comb
    begin
        dx  = $signed({sx[POS_W-1], sx}) - $signed({prev_x_reg[POS_W-1], prev_x_reg});
        dy  = $signed({sy[POS_W-1], sy}) - $signed({prev_y_reg[POS_W-1], prev_y_reg});
        adx = dx[POS_W] ? (POS_W+1)'(-dx) : (POS_W+1)'(dx);
        ady = dy[POS_W] ? (POS_W+1)'(-dy) : (POS_W+1)'(dy);
        far = (adx > {{(POS_W+1-THR_W){1'b0}}, cfg.thresh}) ||
              (ady > {{(POS_W+1-THR_W){1'b0}}, cfg.thresh});
        if (!pressed_reg)
        begin
            emit      = active_reg;
            kind_next = EV_END;
            ev_x      = prev_x_reg;
            ev_y      = prev_y_reg;
            ev_t      = tstamp_reg;
        end
        else
        begin
            emit      = !active_reg || far;
            kind_next = active_reg ? EV_MOVE : EV_START;
            ev_x      = sx;
            ev_y      = sy;
            ev_t      = now_reg;
        end
    end

    // Touch state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            prev_x_reg <= '1;
            prev_y_reg <= '1;
            tstamp_reg <= '0;
        end
        else if (cmd.commit)
        begin
            active_reg <= pressed_reg;
            if (pressed_reg)
            begin
                tstamp_reg <= now_reg;
                if (emit)
                begin
                    prev_x_reg <= sx;
                    prev_y_reg <= sy;
                end
            end
        end
    end

    // Output word
    always_ff @(posedge clk)
    begin
        if (cmd.commit && emit)
        begin
            kind_reg  <= kind_next;
            out_x_reg <= ev_x;
            out_y_reg <= ev_y;
            out_t_reg <= ev_t;
        end
    end

    assign stat.pressed = pressed_reg;
    assign stat.emit    = emit;
    assign event_kind   = kind_reg;
    assign pos_x        = out_x_reg;
    assign pos_y        = out_y_reg;
    assign stamp_ms     = out_t_reg;

endmodule

FILE: rtl/tevg_ctrl.sv
// ----------------------------------------------------------------------------
// Touch event generator controller
// Sequences capture, multiply, divider seeding, the division steps (touched
// polls only) and the commit of each poll; owns the output word's valid flag.
// ----------------------------------------------------------------------------
module tevg_ctrl
    import tevg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output tevg_cmd_t  cmd,
    input  tevg_stat_t stat
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MUL    = 5'b00010,
        ST_PREP   = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_DECIDE = 5'b10000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             vld_reg;
    logic             vld_next;
    logic             slot_free;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        slot_free  = !vld_reg || out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.setup  = 1'b1;
                state_next = stat.pressed ? ST_PREP : ST_DECIDE;
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = CNT_W'(QBITS - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid flag: set on an emitting commit, cleared when taken
    always_comb
    begin
        vld_next = vld_reg;
        if (cmd.commit && stat.emit)
        begin
            vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            vld_reg   <= vld_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = vld_reg;

endmodule

FILE: verif/tevg_checker.sv
// ----------------------------------------------------------------------------
// Touch event checker
// Watches the poll, event and configuration channels of the touch event
// generator. It keeps its own copy of the calibration and the touch state,
// predicts the event word for each accepted poll word, and compares each
// event word that leaves the block with the oldest prediction.
// ----------------------------------------------------------------------------
module tevg_checker
    import tevg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Poll stream
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // raw_x[11:0], raw_y[23:12], now_ms[55:24]
    input  logic                s_tuser,  // pressed
    // Event stream
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,  // pos_x[11:0], pos_y[23:12], stamp_ms[55:24]
    input  logic [KIND_W-1:0]   m_tuser,  // event_kind
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic [31:0]         prdata,
    input  logic                pready,
    // Status for the stimulus side
    output int                  pending,
    output int                  fail_count
);

    localparam int MAX_PRINTED = 60;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [STAMP_W-1:0] stamp;
    } touch_event_t;

    // Predicted event words, oldest first.
    touch_event_t expected_events[$];

    // Local copy of the calibration and of the touch state.
    tevg_cfg_t          cal;
    logic               touch_active;
    int                 last_x;
    int                 last_y;
    logic [STAMP_W-1:0] touch_stamp;

    int printed = 0;

    // Print one line for a mismatch (up to a cap) and count it.
    task automatic report(string what);
        if (printed < MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $realtime, what);
        printed++;
        fail_count++;
    endtask

    // Linear map of one raw reading to screen pixels, truncated toward zero
    // and saturated to the signed 12-bit range.
    function automatic int map_axis(logic [RAW_W-1:0] raw, logic [RAW_W-1:0] lo,
                                    logic [RAW_W-1:0] hi, logic [SIZE_W-1:0] size);
        int r;
        int l;
        int h;
        int s;
        int q;
        r = int'(raw);
        l = int'(lo);
        h = int'(hi);
        s = int'(size);
        if (h == l)
            return 0;
        q = ((r - l) * s) / (h - l);
        if (q > 2047)
            q = 2047;
        if (q < -2048)
            q = -2048;
        return q;
    endfunction

    // Advance the touch state by one poll and queue the event it causes.
    task automatic track_touch(logic pressed, logic [RAW_W-1:0] rx,
                               logic [RAW_W-1:0] ry, logic [STAMP_W-1:0] now);
        int sx;
        int sy;
        int thr;
        int dx;
        int dy;
        touch_event_t ev;
        thr = int'(cal.thresh);
        if (!pressed)
        begin
            if (touch_active)
            begin
                touch_active = 1'b0;
                ev.kind  = EV_END;
                ev.pos_x = last_x[POS_W-1:0];
                ev.pos_y = last_y[POS_W-1:0];
                ev.stamp = touch_stamp;
                expected_events.push_back(ev);
            end
        end
        else
        begin
            touch_stamp = now;
            sx = map_axis(rx, cal.x_min, cal.x_max, cal.width);
            sy = map_axis(ry, cal.y_min, cal.y_max, cal.height);
            dx = (sx > last_x) ? sx - last_x : last_x - sx;
            dy = (sy > last_y) ? sy - last_y : last_y - sy;
            if (!touch_active || dx > thr || dy > thr)
            begin
                ev.kind  = touch_active ? EV_MOVE : EV_START;
                ev.pos_x = sx[POS_W-1:0];
                ev.pos_y = sy[POS_W-1:0];
                ev.stamp = now;
                expected_events.push_back(ev);
                touch_active = 1'b1;
                last_x = sx;
                last_y = sy;
            end
        end
    endtask

    // Channel monitor: compare event words, then follow polls and registers.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        touch_event_t want_ev;
        logic [31:0]  want_rd;
        logic         known;
        if (!rst_n)
        begin
            expected_events.delete();
            cal.x_min    = RST_X_MIN;
            cal.x_max    = RST_X_MAX;
            cal.y_min    = RST_Y_MIN;
            cal.y_max    = RST_Y_MAX;
            cal.width    = RST_WIDTH;
            cal.height   = RST_HEIGHT;
            cal.thresh   = RST_THRESH;
            touch_active = 1'b0;
            last_x       = -1;
            last_y       = -1;
            touch_stamp  = '0;
        end
        else
        begin
            // Event words leave in the order their polls came in.
            if (m_tvalid && m_tready)
            begin
                if (expected_events.size() == 0)
                    report($sformatf("event word with none expected, kind %0d data %h",
                                     m_tuser, m_tdata));
                else
                begin
                    want_ev = expected_events.pop_front();
                    if (m_tuser !== want_ev.kind)
                        report($sformatf("event_kind got %0d expected %0d",
                                         m_tuser, want_ev.kind));
                    if (m_tdata[POS_W-1:0] !== want_ev.pos_x)
                        report($sformatf("pos_x got %h expected %h",
                                         m_tdata[POS_W-1:0], want_ev.pos_x));
                    if (m_tdata[2*POS_W-1:POS_W] !== want_ev.pos_y)
                        report($sformatf("pos_y got %h expected %h",
                                         m_tdata[2*POS_W-1:POS_W], want_ev.pos_y));
                    if (m_tdata[2*POS_W+STAMP_W-1:2*POS_W] !== want_ev.stamp)
                        report($sformatf("stamp_ms got %h expected %h",
                                         m_tdata[2*POS_W+STAMP_W-1:2*POS_W], want_ev.stamp));
                end
            end

            // Each accepted poll word updates the prediction.
            if (s_tvalid && s_tready)
                track_touch(s_tuser, s_tdata[RAW_W-1:0], s_tdata[2*RAW_W-1:RAW_W],
                            s_tdata[2*RAW_W+STAMP_W-1:2*RAW_W]);

            // Register writes; unknown indexes are ignored.
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_X_MIN:  cal.x_min  = pwdata[RAW_W-1:0];
                    REG_X_MAX:  cal.x_max  = pwdata[RAW_W-1:0];
                    REG_Y_MIN:  cal.y_min  = pwdata[RAW_W-1:0];
                    REG_Y_MAX:  cal.y_max  = pwdata[RAW_W-1:0];
                    REG_WIDTH:  cal.width  = pwdata[SIZE_W-1:0];
                    REG_HEIGHT: cal.height = pwdata[SIZE_W-1:0];
                    REG_THRESH: cal.thresh = pwdata[THR_W-1:0];
                    default: ;
                endcase
            end

            // Register reads return the current value.
            if (psel && penable && !pwrite && pready)
            begin
                known   = 1'b1;
                want_rd = '0;
                case (paddr[4:2])
                    REG_X_MIN:  want_rd = 32'(cal.x_min);
                    REG_X_MAX:  want_rd = 32'(cal.x_max);
                    REG_Y_MIN:  want_rd = 32'(cal.y_min);
                    REG_Y_MAX:  want_rd = 32'(cal.y_max);
                    REG_WIDTH:  want_rd = 32'(cal.width);
                    REG_HEIGHT: want_rd = 32'(cal.height);
                    REG_THRESH: want_rd = 32'(cal.thresh);
                    default:    known = 1'b0;
                endcase
                if (known && prdata !== want_rd)
                    report($sformatf("register %0d read %h expected %h",
                                     paddr[4:2], prdata, want_rd));
            end
        end
        pending = expected_events.size();
    end

endmodule

FILE: verif/tb_touch_event_generator.sv
// ----------------------------------------------------------------------------
// Touch event generator testbench
// Drives poll words and calibration settings into the block and lets the
// checker predict and compare every event word. A directed opening covers
// the field extremes and the corner cases of the mapping; random touch
// strokes under changing calibrations follow, with random gaps on both
// streams.
// ----------------------------------------------------------------------------
module tb_touch_event_generator;
    import tevg_pkg::*;

    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         RANDOM_PHASES = 10;
    localparam int         PHASE_POLLS   = 62;
    localparam logic [2:0] REG_UNUSED    = 3'd7;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tuser  = 1'b0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [KIND_W-1:0]   m_tuser;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [4:0]          paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;

    int                  pending;
    int                  fail_count;
    int                  cycle_count = 0;
    int                  stall_left  = 0;
    bit                  calm        = 1'b0;
    logic [STAMP_W-1:0]  poll_ms;

    always #5 clk = ~clk;

    touch_event_generator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tevg_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // Gap length: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Event side back-pressure.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!calm)
                stall_left = pick_gap();
        end
    end

    // Run watchdog.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Offer one poll word and hold it until the block takes it.
    task automatic send_poll(logic pressed, logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry,
                             logic [STAMP_W-1:0] now);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= pressed;
        s_tdata  <= {now, ry, rx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read(logic [2:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering words and let every event word and the datapath drain.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic read_calibration();
        apb_read(REG_X_MIN);
        apb_read(REG_X_MAX);
        apb_read(REG_Y_MIN);
        apb_read(REG_Y_MAX);
        apb_read(REG_WIDTH);
        apb_read(REG_HEIGHT);
        apb_read(REG_THRESH);
    endtask

    // Write a full calibration set while the block is idle, then read it back.
    task automatic load_calibration(tevg_cfg_t c);
        wait_idle();
        apb_write(REG_X_MIN, 32'(c.x_min));
        apb_write(REG_X_MAX, 32'(c.x_max));
        apb_write(REG_Y_MIN, 32'(c.y_min));
        apb_write(REG_Y_MAX, 32'(c.y_max));
        apb_write(REG_WIDTH, 32'(c.width));
        apb_write(REG_HEIGHT, 32'(c.height));
        apb_write(REG_THRESH, 32'(c.thresh));
        read_calibration();
    endtask

    function automatic tevg_cfg_t random_calibration();
        tevg_cfg_t c;
        case ($urandom_range(0, 5))
            0, 1, 2:
            begin
                // Typical panel: wide raw span, modest screen and threshold.
                c.x_min  = RAW_W'($urandom_range(0, 600));
                c.x_max  = RAW_W'($urandom_range(3300, 4095));
                c.y_min  = RAW_W'($urandom_range(0, 600));
                c.y_max  = RAW_W'($urandom_range(3300, 4095));
                if ($urandom_range(0, 1) != 0)
                    c.width = SIZE_W'($urandom_range(1, 480));
                else
                    c.width = SIZE_W'($urandom_range(1, 2047));
                if ($urandom_range(0, 1) != 0)
                    c.height = SIZE_W'($urandom_range(1, 320));
                else
                    c.height = SIZE_W'($urandom_range(1, 2047));
                c.thresh = THR_W'($urandom_range(0, 12));
            end
            3:
            begin
                // Mirrored axes.
                c.x_min  = RAW_W'($urandom_range(3000, 4095));
                c.x_max  = RAW_W'($urandom_range(0, 1000));
                c.y_min  = RAW_W'($urandom_range(3000, 4095));
                c.y_max  = RAW_W'($urandom_range(0, 1000));
                c.width  = SIZE_W'($urandom_range(1, 2047));
                c.height = SIZE_W'($urandom_range(1, 2047));
                c.thresh = THR_W'($urandom_range(0, 40));
            end
            4:
            begin
                // Anything the fields allow.
                c.x_min  = RAW_W'($urandom);
                c.x_max  = RAW_W'($urandom);
                c.y_min  = RAW_W'($urandom);
                c.y_max  = RAW_W'($urandom);
                c.width  = SIZE_W'($urandom);
                c.height = SIZE_W'($urandom);
                c.thresh = THR_W'($urandom);
            end
            default:
            begin
                // One flat axis, threshold at an extreme.
                c.x_min  = RAW_W'($urandom);
                c.x_max  = c.x_min;
                c.y_min  = RAW_W'($urandom_range(0, 200));
                c.y_max  = RAW_W'($urandom_range(3800, 4095));
                c.width  = SIZE_W'($urandom);
                c.height = SIZE_W'($urandom_range(1, 2047));
                c.thresh = $urandom_range(0, 1) ? 8'd0 : 8'd255;
            end
        endcase
        return c;
    endfunction

    function automatic int clamp_raw(int v);
        if (v < 0)
            return 0;
        if (v > 4095)
            return 4095;
        return v;
    endfunction

    // Random touch strokes: press, drag with a random walk, release.
    // A small share of the words are fully random noise.
    task automatic run_strokes(int budget);
        int sent;
        int len;
        int reach;
        int rx;
        int ry;
        sent = 0;
        while (sent < budget)
        begin
            poll_ms += $urandom_range(1, 20);
            if ($urandom_range(0, 9) == 0)
            begin
                send_poll(1'($urandom_range(0, 1)), RAW_W'($urandom), RAW_W'($urandom),
                          STAMP_W'($urandom));
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 24);
                case ($urandom_range(0, 3))
                    0:       reach = 0;
                    1:       reach = 400;
                    default: reach = 40;
                endcase
                rx = $urandom_range(0, 4095);
                ry = $urandom_range(0, 4095);
                repeat (len)
                begin
                    rx = clamp_raw(rx + int'($urandom_range(0, 2 * reach)) - reach);
                    ry = clamp_raw(ry + int'($urandom_range(0, 2 * reach)) - reach);
                    poll_ms += $urandom_range(1, 20);
                    send_poll(1'b1, rx[RAW_W-1:0], ry[RAW_W-1:0], poll_ms);
                    sent++;
                end
                // Most strokes end with a release; some jump straight to a new one.
                if ($urandom_range(0, 5) != 0)
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        poll_ms += $urandom_range(1, 20);
                        send_poll(1'b0, RAW_W'($urandom), RAW_W'($urandom), poll_ms);
                        sent++;
                    end
                end
            end
        end
    endtask

    // Stimulus and verdict.
    initial
    begin : stimulus
        tevg_cfg_t c;
        poll_ms = $urandom;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset values of the registers.
        read_calibration();

        // Default calibration: release while idle, start below the minimum,
        // a small move that only updates the time, release with that time.
        calm = 1'b1;
        send_poll(1'b0, 12'hFFF, 12'hFFF, 32'h0000_0000);
        send_poll(1'b1, 12'd0, 12'd0, 32'h0000_0000);
        send_poll(1'b1, 12'd0, 12'd0, 32'h0000_0007);
        send_poll(1'b0, 12'd0, 12'd0, 32'h0000_0009);
        send_poll(1'b1, 12'd4095, 12'd4095, 32'hFFFF_FFFF);
        send_poll(1'b1, 12'd2000, 12'd2000, 32'h0000_0005);
        send_poll(1'b0, 12'd0, 12'd0, 32'h0000_0006);

        // Steep one-count spans saturate both ways; zero threshold.
        c.x_min  = 12'd4094;
        c.x_max  = 12'd4095;
        c.y_min  = 12'd1;
        c.y_max  = 12'd0;
        c.width  = 11'd2047;
        c.height = 11'd2047;
        c.thresh = 8'd0;
        load_calibration(c);
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        read_calibration();
        calm = 1'b0;
        send_poll(1'b1, 12'd0, 12'd0, 32'h0000_0100);
        send_poll(1'b1, 12'd4095, 12'd4095, 32'h0000_0101);
        send_poll(1'b1, 12'd4095, 12'd4095, 32'h0000_0102);
        send_poll(1'b0, 12'd4095, 12'd4095, 32'h0000_0103);

        // Flat X axis, zero screen height, largest threshold.
        c.x_min  = 12'd2048;
        c.x_max  = 12'd2048;
        c.y_min  = 12'd0;
        c.y_max  = 12'd4095;
        c.width  = 11'd2047;
        c.height = 11'd0;
        c.thresh = 8'd255;
        load_calibration(c);
        send_poll(1'b1, 12'd123, 12'd4095, 32'h8000_0000);
        send_poll(1'b1, 12'd4095, 12'd0, 32'h8000_0001);
        send_poll(1'b0, 12'd0, 12'd0, 32'h8000_0002);

        // Mirrored calibration: a full-span swipe exceeds the threshold.
        c.x_min  = 12'd3807;
        c.x_max  = 12'd219;
        c.y_min  = 12'd3660;
        c.y_max  = 12'd500;
        c.width  = 11'd320;
        c.height = 11'd240;
        c.thresh = 8'd255;
        load_calibration(c);
        send_poll(1'b1, 12'd219, 12'd3660, 32'h0000_1000);
        send_poll(1'b1, 12'd3807, 12'd500, 32'h0000_1001);
        send_poll(1'b0, 12'd0, 12'd0, 32'h0000_1002);

        // Random phases under changing calibrations.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            load_calibration(random_calibration());
            calm = ($urandom_range(0, 3) == 0);
            run_strokes(PHASE_POLLS);
        end

        calm = 1'b0;
        wait_idle();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
